// ===== rtl/m3i_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package m3i_pkg;

  // element format
  localparam int unsigned EW        = 32;
  localparam int unsigned FRAC_BITS = 16;

  // derived widths
  localparam int unsigned PW    = 2 * EW;            // element product
  localparam int unsigned CW    = 2 * EW + 2;        // cofactor, signed
  localparam int unsigned HIW   = CW - EW;           // upper slice of a cofactor
  localparam int unsigned LOPW  = 2 * EW + 1;        // element x lower slice
  localparam int unsigned HIPW  = EW + HIW;          // element x upper slice
  localparam int unsigned DETW  = 3 * EW + 4;        // determinant, signed
  localparam int unsigned MAGW  = DETW - 1;          // determinant magnitude
  localparam int unsigned QW    = EW + 1;            // quotient bits kept
  localparam int unsigned NUMW  = CW + 2 * FRAC_BITS; // shifted numerator
  localparam int unsigned NLANE = 9;

  // cofactor k = m[A]*m[B] - m[C]*m[D], already transposed (adjugate order)
  localparam int unsigned COF_A [NLANE] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int unsigned COF_B [NLANE] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int unsigned COF_C [NLANE] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int unsigned COF_D [NLANE] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  // det = m0*adj0 + m1*adj3 + m2*adj6
  localparam int unsigned DET_COF [3] = '{0, 3, 6};

  // saturation limits on the quotient magnitude
  localparam logic [QW-1:0] QLIM_POS = {2'b00, {(EW - 1){1'b1}}};
  localparam logic [QW-1:0] QLIM_NEG = {2'b01, {(EW - 1){1'b0}}};

  typedef logic signed [EW-1:0] elem_t;

  typedef struct packed {
    elem_t m00;
    elem_t m01;
    elem_t m02;
    elem_t m10;
    elem_t m11;
    elem_t m12;
    elem_t m20;
    elem_t m21;
    elem_t m22;
  } in_t;

  typedef struct packed {
    elem_t r00;
    elem_t r01;
    elem_t r02;
    elem_t r10;
    elem_t r11;
    elem_t r12;
    elem_t r20;
    elem_t r21;
    elem_t r22;
    logic  singular;
  } out_t;

  typedef struct packed {
    logic [MAGW-1:0] rem;
    logic [QW-1:0]   q;
    logic [QW-1:0]   nbits;
    logic            neg;
    logic            sat;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [NLANE-1:0] lane;
    logic [MAGW-1:0]       dmag;
    logic                  singular;
  } div_state_t;

endpackage

`default_nettype wire

// ===== rtl/matrix3_inverse_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// 3x3 matrix inverse, signed Q16.16 in and out.
// Input channel: one beat is a whole matrix in row-major order (in_data_i),
// taken when in_valid_i is high and in_stall_o is low.
// Output channel: one beat per matrix, the inverse in row-major order plus a
// singular flag; taken when out_valid_o is high and out_stall_i is low.
// Quotients out of range saturate; a zero determinant gives all-zero elements
// with singular set.
// Pipeline: 6 front stages, 33 divider steps and 1 output register lie between
// an accepted input beat and its output beat.
// Throughput: one matrix per cycle while not stalled; every stage is a register
// with its own valid bit; nine divider lanes each take one quotient bit per stage.
// Stall: out_stall_i holds the output register; stages behind it keep filling
// their empty slots and in_stall_o rises only once the pipe is full.
// Reset: asynchronous, clears all valid bits; the block takes beats at once.
module matrix3_inverse_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  m3i_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output m3i_pkg::out_t out_data_o
);

  logic [m3i_pkg::QW:0] dv;
  logic [m3i_pkg::QW:0] dr;
  m3i_pkg::div_state_t  dst [m3i_pkg::QW+1];
  logic                 front_ready;

  logic                 out_en;
  logic                 out_valid_q;
  m3i_pkg::out_t        out_data_q;
  m3i_pkg::out_t        out_data_d;

  m3i_pkg::elem_t       res [m3i_pkg::NLANE];
  logic [m3i_pkg::QW-1:0] lim;
  logic [m3i_pkg::QW-1:0] mag;
  logic [m3i_pkg::QW-1:0] sval;

  assign in_stall_o = !front_ready;

  m3i_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (front_ready),
    .data_i  (in_data_i),
    .valid_o (dv[0]),
    .ready_i (dr[0]),
    .state_o (dst[0])
  );

  // divider: one quotient bit per stage, MSB first
  for (genvar k = 0; k < m3i_pkg::QW; k++) begin : g_div
    m3i_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv[k]),
      .ready_o (dr[k]),
      .state_i (dst[k]),
      .valid_o (dv[k+1]),
      .ready_i (dr[k+1]),
      .state_o (dst[k+1])
    );
  end

  assign out_en         = !out_valid_q || !out_stall_i;
  assign dr[m3i_pkg::QW] = out_en;

  // sign, saturation, singular override
  always_comb begin
    lim  = '0;
    mag  = '0;
    sval = '0;
    for (int i = 0; i < m3i_pkg::NLANE; i++) begin
      lim  = dst[m3i_pkg::QW].lane[i].neg ? m3i_pkg::QLIM_NEG : m3i_pkg::QLIM_POS;
      mag  = (dst[m3i_pkg::QW].lane[i].sat || dst[m3i_pkg::QW].lane[i].q > lim)
             ? lim : dst[m3i_pkg::QW].lane[i].q;
      sval = dst[m3i_pkg::QW].lane[i].neg ? (m3i_pkg::QW'(0) - mag) : mag;
      res[i] = dst[m3i_pkg::QW].singular ? '0 : m3i_pkg::elem_t'(sval[m3i_pkg::EW-1:0]);
    end
  end

  always_comb begin
    out_data_d.r00      = res[0];
    out_data_d.r01      = res[1];
    out_data_d.r02      = res[2];
    out_data_d.r10      = res[3];
    out_data_d.r11      = res[4];
    out_data_d.r12      = res[5];
    out_data_d.r20      = res[6];
    out_data_d.r21      = res[7];
    out_data_d.r22      = res[8];
    out_data_d.singular = dst[m3i_pkg::QW].singular;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= dv[m3i_pkg::QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== rtl/m3i_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Products, cofactors, determinant and divider setup: six stages.
module m3i_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  m3i_pkg::in_t         data_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output m3i_pkg::div_state_t  state_o
);

  localparam int unsigned NS = 6;

  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  m3i_pkg::elem_t m [m3i_pkg::NLANE];

  logic signed [m3i_pkg::PW-1:0]   prod_a_q [m3i_pkg::NLANE];
  logic signed [m3i_pkg::PW-1:0]   prod_b_q [m3i_pkg::NLANE];
  m3i_pkg::elem_t                  mt1_q [3];
  m3i_pkg::elem_t                  mt2_q [3];
  logic signed [m3i_pkg::CW-1:0]   cof2_q [m3i_pkg::NLANE];
  logic signed [m3i_pkg::CW-1:0]   cof3_q [m3i_pkg::NLANE];
  logic signed [m3i_pkg::CW-1:0]   cof4_q [m3i_pkg::NLANE];
  logic signed [m3i_pkg::CW-1:0]   cof5_q [m3i_pkg::NLANE];
  logic signed [m3i_pkg::LOPW-1:0] lo_q [3];
  logic signed [m3i_pkg::HIPW-1:0] hi_q [3];
  logic signed [m3i_pkg::DETW-1:0] term_q [3];
  logic signed [m3i_pkg::DETW-1:0] det_q;

  logic [m3i_pkg::CW-1:0]   cmag;
  logic [m3i_pkg::NUMW-1:0] num;
  logic [m3i_pkg::DETW-1:0] dabs;
  m3i_pkg::div_state_t      setup_d;
  m3i_pkg::div_state_t      state_q;

  assign m[0] = data_i.m00;
  assign m[1] = data_i.m01;
  assign m[2] = data_i.m02;
  assign m[3] = data_i.m10;
  assign m[4] = data_i.m11;
  assign m[5] = data_i.m12;
  assign m[6] = data_i.m20;
  assign m[7] = data_i.m21;
  assign m[8] = data_i.m22;

  // a stage loads when empty or when its contents move on
  assign en[NS] = ready_i;
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];
  assign state_o = state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 1: element products
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < m3i_pkg::NLANE; i++) begin
        prod_a_q[i] <= m[m3i_pkg::COF_A[i]] * m[m3i_pkg::COF_B[i]];
        prod_b_q[i] <= m[m3i_pkg::COF_C[i]] * m[m3i_pkg::COF_D[i]];
      end
      for (int t = 0; t < 3; t++) mt1_q[t] <= m[t];
    end
  end

  // stage 2: cofactors
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int i = 0; i < m3i_pkg::NLANE; i++) begin
        cof2_q[i] <= m3i_pkg::CW'(prod_a_q[i]) - m3i_pkg::CW'(prod_b_q[i]);
      end
      mt2_q <= mt1_q;
    end
  end

  // stage 3: first-row terms, cofactor split into two slices
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int t = 0; t < 3; t++) begin
        lo_q[t] <= mt2_q[t] *
                   $signed({1'b0, cof2_q[m3i_pkg::DET_COF[t]][m3i_pkg::EW-1:0]});
        hi_q[t] <= mt2_q[t] *
                   $signed(cof2_q[m3i_pkg::DET_COF[t]][m3i_pkg::CW-1:m3i_pkg::EW]);
      end
      cof3_q <= cof2_q;
    end
  end

  // stage 4: recombine slices
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int t = 0; t < 3; t++) begin
        term_q[t] <= (m3i_pkg::DETW'(hi_q[t]) <<< m3i_pkg::EW) +
                     m3i_pkg::DETW'(lo_q[t]);
      end
      cof4_q <= cof3_q;
    end
  end

  // stage 5: determinant
  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      det_q  <= term_q[0] + term_q[1] + term_q[2];
      cof5_q <= cof4_q;
    end
  end

  // stage 6: magnitudes, signs, overflow pre-check, first remainder
  always_comb begin
    cmag    = '0;
    num     = '0;
    setup_d = '0;
    dabs    = det_q[m3i_pkg::DETW-1] ? m3i_pkg::DETW'(-det_q) : m3i_pkg::DETW'(det_q);
    setup_d.dmag     = dabs[m3i_pkg::MAGW-1:0];
    setup_d.singular = (det_q == '0);
    for (int i = 0; i < m3i_pkg::NLANE; i++) begin
      cmag = cof5_q[i][m3i_pkg::CW-1] ? m3i_pkg::CW'(-cof5_q[i])
                                      : m3i_pkg::CW'(cof5_q[i]);
      num  = {cmag, {(2 * m3i_pkg::FRAC_BITS){1'b0}}};
      setup_d.lane[i].nbits = num[m3i_pkg::QW-1:0];
      setup_d.lane[i].rem   = m3i_pkg::MAGW'(num[m3i_pkg::NUMW-1:m3i_pkg::QW]);
      setup_d.lane[i].sat   = m3i_pkg::MAGW'(num[m3i_pkg::NUMW-1:m3i_pkg::QW]) >=
                              dabs[m3i_pkg::MAGW-1:0];
      setup_d.lane[i].neg   = cof5_q[i][m3i_pkg::CW-1] ^ det_q[m3i_pkg::DETW-1];
      setup_d.lane[i].q     = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) state_q <= setup_d;
  end

endmodule

`default_nettype wire

// ===== rtl/m3i_div_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One restoring division step for all nine lanes.
module m3i_div_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  m3i_pkg::div_state_t state_i,
  output logic                valid_o,
  input  logic                ready_i,
  output m3i_pkg::div_state_t state_o
);

  logic                    valid_q;
  logic                    en;
  m3i_pkg::div_state_t     state_d;
  m3i_pkg::div_state_t     state_q;
  logic [m3i_pkg::MAGW:0]  shifted;
  logic [m3i_pkg::MAGW:0]  diff;
  logic                    ge;

  assign en      = !valid_q || ready_i;
  assign ready_o = en;
  assign valid_o = valid_q;
  assign state_o = state_q;

  always_comb begin
    state_d = state_i;
    shifted = '0;
    diff    = '0;
    ge      = 1'b0;
    for (int i = 0; i < m3i_pkg::NLANE; i++) begin
      shifted = {state_i.lane[i].rem, state_i.lane[i].nbits[m3i_pkg::QW-1]};
      diff    = shifted - {1'b0, state_i.dmag};
      ge      = shifted >= {1'b0, state_i.dmag};
      state_d.lane[i].rem   = ge ? diff[m3i_pkg::MAGW-1:0] : shifted[m3i_pkg::MAGW-1:0];
      state_d.lane[i].q     = {state_i.lane[i].q[m3i_pkg::QW-2:0], ge};
      state_d.lane[i].nbits = {state_i.lane[i].nbits[m3i_pkg::QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) state_q <= state_d;
  end

endmodule

`default_nettype wire

// ===== rtl/m3i_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module m3i_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input m3i_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input m3i_pkg::out_t out_data_o
);

  // a stalled input beat stays put
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("input beat changed under stall");

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result beat changed under stall");

  // singular matrix gives an all-zero inverse
  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.singular |->
      out_data_o.r00 == '0 && out_data_o.r01 == '0 && out_data_o.r02 == '0 &&
      out_data_o.r10 == '0 && out_data_o.r11 == '0 && out_data_o.r12 == '0 &&
      out_data_o.r20 == '0 && out_data_o.r21 == '0 && out_data_o.r22 == '0)
    else $error("singular result with non-zero element");

  // pipe can only push back once the output register holds a beat
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output empty");

endmodule

bind matrix3_inverse_unit m3i_checker u_m3i_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  typedef m3i_pkg::in_t   in_t;
  typedef m3i_pkg::out_t  out_t;
  typedef m3i_pkg::elem_t elem_t;
  localparam int unsigned FRAC_BITS = m3i_pkg::FRAC_BITS;

  localparam int unsigned LIMIT_CYCLES = 5000;
  localparam int unsigned DRAIN_CYCLES = 60;

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_stall_o;
  in_t   in_data_i;
  logic  out_valid_o;
  logic  out_stall_i;
  out_t  out_data_o;

  matrix3_inverse_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // expected inverses, oldest first
  out_t inverse_q[$];
  int   mismatch_cnt;
  int   idle_cnt;
  bit   timed_out;
  bit   sender_busy;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor: exact wide integer arithmetic. Cofactors fit in 66 bits and the
  // determinant in 100; 200-bit signed working values leave ample headroom for
  // the numerator shifted up by 2*FRAC_BITS.
  // ---------------------------------------------------------------------------
  typedef logic signed [199:0] wide_t;

  function automatic elem_t sat_quotient(wide_t cof, wide_t det);
    wide_t num, quo;
    wide_t hi, lo;
    num = cof <<< (2 * FRAC_BITS);
    quo = num / det;   // truncates toward zero
    hi  = (wide_t'(1) <<< 31) - wide_t'(1);
    lo  = -(wide_t'(1) <<< 31);
    if (quo > hi) return elem_t'(32'h7fff_ffff);
    if (quo < lo) return elem_t'(32'h8000_0000);
    return elem_t'(quo[31:0]);
  endfunction

  function automatic out_t predict_inverse(in_t mat);
    wide_t e [9];
    wide_t adj [9];
    wide_t det;
    out_t  res;
    e[0] = mat.m00; e[1] = mat.m01; e[2] = mat.m02;
    e[3] = mat.m10; e[4] = mat.m11; e[5] = mat.m12;
    e[6] = mat.m20; e[7] = mat.m21; e[8] = mat.m22;
    // adjugate, i.e. cofactors already transposed
    adj[0] = e[4] * e[8] - e[5] * e[7];
    adj[1] = e[2] * e[7] - e[1] * e[8];
    adj[2] = e[1] * e[5] - e[2] * e[4];
    adj[3] = e[5] * e[6] - e[3] * e[8];
    adj[4] = e[0] * e[8] - e[2] * e[6];
    adj[5] = e[2] * e[3] - e[0] * e[5];
    adj[6] = e[3] * e[7] - e[4] * e[6];
    adj[7] = e[1] * e[6] - e[0] * e[7];
    adj[8] = e[0] * e[4] - e[1] * e[3];
    det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
    res = '0;
    if (det == 0) begin
      res.singular = 1'b1;
    end else begin
      res.r00 = sat_quotient(adj[0], det);
      res.r01 = sat_quotient(adj[1], det);
      res.r02 = sat_quotient(adj[2], det);
      res.r10 = sat_quotient(adj[3], det);
      res.r11 = sat_quotient(adj[4], det);
      res.r12 = sat_quotient(adj[5], det);
      res.r20 = sat_quotient(adj[6], det);
      res.r21 = sat_quotient(adj[7], det);
      res.r22 = sat_quotient(adj[8], det);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps between them. The gap counter
  // runs on the driving side so valid never looks at stall.
  // ---------------------------------------------------------------------------
  int burst_left;

  task automatic send_matrix(input in_t mat);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= mat;
    inverse_q.push_back(predict_inverse(mat));
    // hold the beat until taken
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // valid stays up after acceptance, so a burst runs back to back: the next
  // call drives its beat on the accepting edge, or drops valid for a gap

  function automatic elem_t q16(int whole);
    return elem_t'(whole <<< FRAC_BITS);
  endfunction

  function automatic in_t diag(elem_t a, elem_t b, elem_t c);
    in_t mat;
    mat = '0;
    mat.m00 = a; mat.m11 = b; mat.m22 = c;
    return mat;
  endfunction

  function automatic elem_t rand_elem();
    case ($urandom_range(0, 5))
      0:       return elem_t'($urandom);
      1:       return elem_t'($signed($urandom_range(0, 32'h7_ffff)) - 32'sh4_0000);
      2:       return elem_t'($signed($urandom_range(0, 32'hff)) - 32'sh80);
      3:       return ($urandom_range(0, 1)) ? elem_t'(32'h7fff_ffff) : elem_t'(32'h8000_0000);
      default: return elem_t'($signed($urandom_range(0, 32'h3f_ffff)) - 32'sh20_0000);
    endcase
  endfunction

  function automatic in_t rand_matrix();
    in_t mat;
    mat.m00 = rand_elem(); mat.m01 = rand_elem(); mat.m02 = rand_elem();
    mat.m10 = rand_elem(); mat.m11 = rand_elem(); mat.m12 = rand_elem();
    mat.m20 = rand_elem(); mat.m21 = rand_elem(); mat.m22 = rand_elem();
    // now and then make it singular: copy one row into another or clear a column
    if ($urandom_range(0, 7) == 0) begin
      mat.m20 = mat.m00; mat.m21 = mat.m01; mat.m22 = mat.m02;
    end else if ($urandom_range(0, 15) == 0) begin
      mat.m01 = '0; mat.m11 = '0; mat.m21 = '0;
    end
    return mat;
  endfunction

  // ---------------------------------------------------------------------------
  // Test tasks
  // ---------------------------------------------------------------------------
  task automatic test_identity_and_scaling();
    in_t mat;
    send_matrix(diag(q16(1), q16(1), q16(1)));
    send_matrix(diag(q16(2), q16(-4), elem_t'(32'sh0000_8000)));
    send_matrix(diag(q16(-1), q16(3), q16(7)));
    // tiny diagonal: inverse overflows both ways
    send_matrix(diag(elem_t'(1), elem_t'(-1), elem_t'(1)));
    // huge diagonal: inverse elements are only two ulp in magnitude
    send_matrix(diag(elem_t'(32'h7fff_ffff), elem_t'(32'h8000_0000), elem_t'(32'h7fff_ffff)));
    // permutation matrix
    mat = '0;
    mat.m01 = q16(1); mat.m12 = q16(1); mat.m20 = q16(1);
    send_matrix(mat);
    // general matrix, checks the adjugate is transposed
    mat.m00 = q16(2); mat.m01 = q16(3); mat.m02 = q16(1);
    mat.m10 = q16(0); mat.m11 = q16(1); mat.m12 = q16(4);
    mat.m20 = q16(5); mat.m21 = q16(6); mat.m22 = q16(0);
    send_matrix(mat);
  endtask

  task automatic test_singular();
    in_t mat;
    send_matrix('0);
    mat = '1;   // all -ulp: rank one
    send_matrix(mat);
    mat = {9{elem_t'(32'h8000_0000)}};
    send_matrix(mat);
    mat = {9{elem_t'(32'h7fff_ffff)}};
    send_matrix(mat);
    mat = diag(q16(1), q16(1), '0);
    send_matrix(mat);
  endtask

  task automatic test_extremes();
    in_t mat;
    mat = diag(elem_t'(32'h8000_0000), elem_t'(32'h8000_0000), elem_t'(32'h8000_0000));
    mat.m01 = elem_t'(32'h7fff_ffff); mat.m20 = elem_t'(32'h7fff_ffff);
    send_matrix(mat);
    mat = diag(elem_t'(32'h7fff_ffff), elem_t'(32'h7fff_ffff), elem_t'(32'h7fff_ffff));
    mat.m02 = elem_t'(32'h8000_0000); mat.m10 = elem_t'(1);
    send_matrix(mat);
    mat = {elem_t'(32'h5555_5555), elem_t'(32'haaaa_aaaa), elem_t'(1),
           elem_t'(32'haaaa_aaaa), elem_t'(32'h5555_5555), elem_t'(-2),
           elem_t'(3), elem_t'(32'hffff_0000), elem_t'(32'h0001_0000)};
    send_matrix(mat);
  endtask

  task automatic test_random_matrices(input int count);
    repeat (count) send_matrix(rand_matrix());
  endtask

  // ---------------------------------------------------------------------------
  // Receiver stall pattern: alternates between quiet stretches, random stall
  // and long holds so stalls land on every stage of the pipe filling.
  // ---------------------------------------------------------------------------
  int stall_mode;
  int stall_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_mode  <= 0;
      stall_left  <= 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(10, 120);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 1) == 0);
        2:       out_stall_i <= ($urandom_range(0, 7) != 0);
        default: out_stall_i <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker and watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !sender_busy)
        idle_cnt <= 0;
      else
        idle_cnt <= idle_cnt + 1;
      if (out_valid_o && !out_stall_i) begin
        if (inverse_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected inverse beat %h", out_data_o);
        end else begin
          want = inverse_q.pop_front();
          if (out_data_o !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("inverse mismatch: want %h got %h", want, out_data_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cnt >= LIMIT_CYCLES && !timed_out) begin
      timed_out = 1'b1;
      $display("matrix3_inverse_unit regression: fail");
      $finish;
    end
  end

  initial begin
    int drain;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    mismatch_cnt = 0;
    idle_cnt     = 0;
    timed_out    = 1'b0;
    burst_left   = 0;
    sender_busy  = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_identity_and_scaling();
    test_singular();
    test_extremes();
    test_random_matrices(700);
    in_valid_i <= 1'b0;

    drain = 0;
    while (inverse_q.size() != 0 && drain < 20 * LIMIT_CYCLES) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    sender_busy = 1'b0;

    if (mismatch_cnt == 0 && inverse_q.size() == 0)
      $display("matrix3_inverse_unit regression: pass");
    else
      $display("matrix3_inverse_unit regression: fail");
    $finish;
  end

endmodule
